[rtl/idsq_pkg.sv]
// ----------------------------------------------------------------------------
// idsq_pkg - shared types and constants for the influence grid core
// Item layouts, op codes, weight codes and register indexes.
// ----------------------------------------------------------------------------
package idsq_pkg;

    // default build sizes
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_RADIUS = 15;

    localparam int CELL_W  = 24;          // u16.8 cell value
    localparam int SUM_W   = 29;          // weighted sum width
    localparam int SIZE_W  = 7;           // size register width
    localparam int COORD_W = 10;          // signed cell coordinate, holds -512..511

    localparam logic [CELL_W-1:0] CELL_MAX   = '1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // op codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // kernel weight codes
    localparam logic [1:0] WT_1 = 2'd0;
    localparam logic [1:0] WT_2 = 2'd1;
    localparam logic [1:0] WT_5 = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic        [1:0]        op;
        logic signed [7:0]        col;
        logic signed [7:0]        row;
        logic        [3:0]        radius;
        logic signed [CELL_W-1:0] amount;
    } req_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] weighted_sum;
        logic             done_res;
    } rsp_item_t;

    typedef struct packed {
        logic       query;   // 1: accumulate, 0: saturating cell update
        logic [1:0] weight;
    } alu_ctrl_t;

endpackage

[rtl/idsq_grid_mem.sv]
// ----------------------------------------------------------------------------
// idsq_grid_mem - cell value store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module idsq_grid_mem #(
    parameter int DEPTH = idsq_pkg::DEF_MAX_WIDTH * idsq_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic [idsq_pkg::CELL_W-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output logic [idsq_pkg::CELL_W-1:0] rdata
);

    logic [idsq_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/idsq_cell_alu.sv]
// ----------------------------------------------------------------------------
// idsq_cell_alu - shared adder for cell updates and query accumulation
// Add mode: cell + amount clamped to [0, CELL_MAX].
// Query mode: acc + weight * cell.
// ----------------------------------------------------------------------------
module idsq_cell_alu (
    input  idsq_pkg::alu_ctrl_t                ctrl,
    input  logic        [idsq_pkg::CELL_W-1:0] cur_val,
    input  logic signed [idsq_pkg::CELL_W-1:0] amount,
    input  logic        [idsq_pkg::SUM_W-1:0]  acc,
    output logic        [idsq_pkg::CELL_W-1:0] new_cell,
    output logic        [idsq_pkg::SUM_W-1:0]  new_acc
);

    localparam int OPW = idsq_pkg::SUM_W + 2;
    localparam int WW  = idsq_pkg::CELL_W + 3;

    logic        [WW-1:0]  weighted;
    logic signed [OPW-1:0] opa;
    logic signed [OPW-1:0] opb;
    logic signed [OPW-1:0] sum;

    always_comb
    begin
        case (ctrl.weight)
            idsq_pkg::WT_1: weighted = WW'(cur_val);
            idsq_pkg::WT_2: weighted = WW'(cur_val) << 1;
            idsq_pkg::WT_5: weighted = (WW'(cur_val) << 2) + WW'(cur_val);
            default:        weighted = '0;
        endcase
    end

    always_comb
    begin
        if (ctrl.query)
        begin
            opa = $signed(OPW'(acc));
            opb = $signed(OPW'(weighted));
        end
        else
        begin
            opa = $signed(OPW'(cur_val));
            opb = OPW'(amount);
        end
        sum = opa + opb;
    end

    always_comb
    begin
        if (sum < 0)
        begin
            new_cell = '0;
        end
        else if (sum > $signed(OPW'(idsq_pkg::CELL_MAX)))
        begin
            new_cell = idsq_pkg::CELL_MAX;
        end
        else
        begin
            new_cell = sum[idsq_pkg::CELL_W-1:0];
        end
    end

    assign new_acc = sum[idsq_pkg::SUM_W-1:0];

endmodule

[rtl/idsq_seq.sv]
// ----------------------------------------------------------------------------
// idsq_seq - scan sequencer
// Walks the disc or 3x3 window one cell a cycle, read then write next cycle;
// also runs the clear sweep.
// ----------------------------------------------------------------------------
module idsq_seq #(
    parameter int MAX_WIDTH  = idsq_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = idsq_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = idsq_pkg::DEF_MAX_RADIUS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  idsq_pkg::req_item_t                    item,
    input  logic [idsq_pkg::SIZE_W-1:0]            grid_width,
    input  logic [idsq_pkg::SIZE_W-1:0]            grid_height,
    input  logic                                   res_free,
    output logic                                   busy,
    output logic                                   finish,
    output logic [idsq_pkg::SUM_W-1:0]             sum,
    output logic                                   mem_we,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] mem_waddr,
    output logic [idsq_pkg::CELL_W-1:0]            mem_wdata,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] mem_raddr,
    output idsq_pkg::alu_ctrl_t                    alu_ctrl,
    output logic signed [idsq_pkg::CELL_W-1:0]     alu_amount,
    output logic [idsq_pkg::SUM_W-1:0]             alu_acc,
    input  logic [idsq_pkg::CELL_W-1:0]            alu_new_cell,
    input  logic [idsq_pkg::SUM_W-1:0]             alu_new_acc
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int OW    = RW + 1;
    localparam int SQW   = 2 * RW + 1;
    localparam int CW    = idsq_pkg::COORD_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [1:0]                     op_reg;
    logic signed [7:0]              col_reg, row_reg;
    logic signed [idsq_pkg::CELL_W-1:0] amount_reg;
    logic [RW-1:0]                  r_reg;
    logic [SQW-1:0]                 rsq_reg, isq_reg, jsq_reg;
    logic signed [OW-1:0]           i_reg, j_reg;
    logic [AW-1:0]                  clr_cnt_reg;
    logic                           clr_op_reg;
    logic [idsq_pkg::SUM_W-1:0]     acc_reg;
    logic                           p_valid_reg;
    logic [AW-1:0]                  p_addr_reg;
    logic [1:0]                     p_weight_reg;

    logic [CW-2:0]                  w_eff, h_eff;
    logic signed [CW-1:0]           x_c, y_c, cx_c, cy_c;
    logic                           x_in, y_in, center_in;
    logic [SQW-1:0]                 dsq;
    logic                           hit, is_query;
    logic [1:0]                     weight;
    logic signed [OW-1:0]           r_s;
    logic                           j_last, i_last, clr_last;
    logic [SQW-1:0]                 rsq_mul;
    logic signed [SQW:0]            istep, jstep;
    logic [RW-1:0]                  r_start;

    // effective sizes
    assign w_eff = (32'(grid_width) > MAX_WIDTH)  ? (CW-1)'(MAX_WIDTH)  : (CW-1)'(grid_width);
    assign h_eff = (32'(grid_height) > MAX_HEIGHT) ? (CW-1)'(MAX_HEIGHT) : (CW-1)'(grid_height);

    // current cell
    assign x_c  = CW'(col_reg) + CW'(i_reg);
    assign y_c  = CW'(row_reg) + CW'(j_reg);
    assign x_in = !x_c[CW-1] && (x_c[CW-2:0] < w_eff);
    assign y_in = !y_c[CW-1] && (y_c[CW-2:0] < h_eff);
    assign cx_c = CW'(col_reg);
    assign cy_c = CW'(row_reg);
    assign center_in = !cx_c[CW-1] && (cx_c[CW-2:0] < w_eff)
                    && !cy_c[CW-1] && (cy_c[CW-2:0] < h_eff);

    assign is_query = (op_reg == idsq_pkg::OP_QUERY);
    assign dsq      = isq_reg + jsq_reg;
    assign hit      = x_in && y_in && (is_query || (dsq <= rsq_reg));

    always_comb
    begin
        if (i_reg == 0 && j_reg == 0)
        begin
            weight = idsq_pkg::WT_5;
        end
        else if (i_reg == 0 || j_reg == 0)
        begin
            weight = idsq_pkg::WT_2;
        end
        else
        begin
            weight = idsq_pkg::WT_1;
        end
    end

    assign mem_raddr = AW'(32'(y_c[CW-2:0]) * MAX_WIDTH + 32'(x_c[CW-2:0]));

    // scan step bookkeeping: (k+1)^2 = k^2 + 2k + 1
    assign r_s      = $signed({1'b0, r_reg});
    assign j_last   = (j_reg == r_s);
    assign i_last   = (i_reg == r_s);
    assign rsq_mul  = SQW'(r_reg) * SQW'(r_reg);
    assign istep    = $signed({1'b0, isq_reg}) + (SQW+1)'($signed({i_reg, 1'b1}));
    assign jstep    = $signed({1'b0, jsq_reg}) + (SQW+1)'($signed({j_reg, 1'b1}));
    assign clr_last = (clr_cnt_reg == AW'(DEPTH - 1));
    assign r_start  = (32'(item.radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(item.radius);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = clr_op_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (item.op == idsq_pkg::OP_ADD || item.op == idsq_pkg::OP_QUERY)
                    begin
                        state_next = S_SETUP;
                    end
                    else if (item.op == idsq_pkg::OP_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SETUP:
            begin
                state_next = (is_query && !center_in) ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                if (i_last && j_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            clr_op_reg  <= 1'b0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= (state_reg == S_SCAN) && hit;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (start)
            begin
                clr_cnt_reg <= '0;
                clr_op_reg  <= 1'b1;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg     <= item.op;
            col_reg    <= item.col;
            row_reg    <= item.row;
            amount_reg <= item.amount;
            r_reg      <= (item.op == idsq_pkg::OP_QUERY) ? RW'(1) : r_start;
            acc_reg    <= '0;
        end
        if (state_reg == S_SETUP)
        begin
            rsq_reg <= rsq_mul;
            isq_reg <= rsq_mul;
            jsq_reg <= rsq_mul;
            i_reg   <= -r_s;
            j_reg   <= -r_s;
        end
        if (state_reg == S_SCAN)
        begin
            p_addr_reg   <= mem_raddr;
            p_weight_reg <= weight;
            if (j_last)
            begin
                j_reg   <= -r_s;
                jsq_reg <= rsq_reg;
                i_reg   <= i_reg + 1'b1;
                isq_reg <= istep[SQW-1:0];
            end
            else
            begin
                j_reg   <= j_reg + 1'b1;
                jsq_reg <= jstep[SQW-1:0];
            end
        end
        if (p_valid_reg && is_query)
        begin
            acc_reg <= alu_new_acc;
        end
    end

    // write port: clear sweep or second half of a cell update
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = p_valid_reg && !is_query;
            mem_waddr = p_addr_reg;
            mem_wdata = alu_new_cell;
        end
    end

    assign alu_ctrl.query  = is_query;
    assign alu_ctrl.weight = p_weight_reg;
    assign alu_amount      = amount_reg;
    assign alu_acc         = acc_reg;

    assign busy   = (state_reg != S_IDLE);
    assign finish = (state_reg == S_DONE) && res_free;
    assign sum    = acc_reg;

    // checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("start outside idle");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> state_reg == S_IDLE)
        else $error("finish did not return to idle");

    a_stage_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> $past(state_reg == S_SCAN))
        else $error("update stage loaded outside scan");

    a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (mem_we && mem_wdata == '0 && !p_valid_reg))
        else $error("clear sweep write wrong");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR) || (p_valid_reg && !is_query))
        else $error("unexpected grid write");

endmodule

[rtl/influence_grid_disc_stamp_and_query_core.sv]
// ----------------------------------------------------------------------------
// influence_grid_disc_stamp_and_query_core - influence grid top level
// Disc stamp, 3x3 weighted query and clear over a cell grid, with an
// APB-style port for the grid size registers.
// ----------------------------------------------------------------------------
//
//  channel | signals                        | beat
//  --------+--------------------------------+--------------------------------
//  req     | req_valid, req_stall, req      | op, col, row, radius, amount
//  rsp     | rsp_valid, rsp_stall, rsp      | weighted_sum, done_res
//  cfg     | psel, penable, pwrite, paddr,  | grid_width @0, grid_height @4
//          | pwdata, prdata, pready         |
//
//  Per beat: add scans the (2r+1)^2 square, query the 3x3 window (none
//    for an off-map center), clear sweeps the grid, other ops do no work.
//    The scan visits one cell a cycle over separate read and write ports.
//  Reset: a clearing pass zeroes the grid; req_stall stays high until
//    it ends. Register writes are taken anytime.
//  Stalls: req_stall is high while an op is in flight; a finished result
//    waits in the output register, and the next req beat is taken meanwhile.
// ----------------------------------------------------------------------------
module influence_grid_disc_stamp_and_query_core #(
    parameter int MAX_WIDTH  = idsq_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = idsq_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = idsq_pkg::DEF_MAX_RADIUS
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                req_valid,
    output logic                req_stall,
    input  idsq_pkg::req_item_t req,
    // result channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output idsq_pkg::rsp_item_t rsp,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [idsq_pkg::SIZE_W-1:0]     grid_width_reg, grid_height_reg;
    logic                            rsp_valid_reg;
    idsq_pkg::rsp_item_t             rsp_reg;

    logic                            start, busy, finish, res_free;
    logic [idsq_pkg::SUM_W-1:0]      sum;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr, mem_raddr;
    logic [idsq_pkg::CELL_W-1:0]     mem_wdata, mem_rdata;
    idsq_pkg::alu_ctrl_t             alu_ctrl;
    logic signed [idsq_pkg::CELL_W-1:0] alu_amount;
    logic [idsq_pkg::SUM_W-1:0]      alu_acc, alu_new_acc;
    logic [idsq_pkg::CELL_W-1:0]     alu_new_cell;
    logic                            cfg_wr;

    // config registers; register index is paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= idsq_pkg::SIZE_RESET;
            grid_height_reg <= idsq_pkg::SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                idsq_pkg::REG_GRID_WIDTH:  grid_width_reg  <= pwdata[idsq_pkg::SIZE_W-1:0];
                idsq_pkg::REG_GRID_HEIGHT: grid_height_reg <= pwdata[idsq_pkg::SIZE_W-1:0];
                default:                   grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            idsq_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width_reg);
            idsq_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height_reg);
            default:                   prdata = '0;
        endcase
    end

    // request side: taken only while the sequencer idles
    assign req_stall = busy;
    assign start     = req_valid && !busy;

    // result register; freed when empty or being taken this cycle
    assign res_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            rsp_reg.weighted_sum <= sum;
            rsp_reg.done_res     <= 1'b1;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    idsq_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (req),
        .grid_width   (grid_width_reg),
        .grid_height  (grid_height_reg),
        .res_free     (res_free),
        .busy         (busy),
        .finish       (finish),
        .sum          (sum),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .alu_ctrl     (alu_ctrl),
        .alu_amount   (alu_amount),
        .alu_acc      (alu_acc),
        .alu_new_cell (alu_new_cell),
        .alu_new_acc  (alu_new_acc)
    );

    idsq_grid_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    idsq_cell_alu u_alu (
        .ctrl     (alu_ctrl),
        .cur_val  (mem_rdata),
        .amount   (alu_amount),
        .acc      (alu_acc),
        .new_cell (alu_new_cell),
        .new_acc  (alu_new_acc)
    );

endmodule

[verif/tb_influence_grid_disc_stamp_and_query_core.sv]
// ----------------------------------------------------------------------------
// tb_influence_grid_disc_stamp_and_query_core - self-checking bench
// Drives disc adds, 3x3 queries, clears and unused ops through the request
// channel under several grid sizes. A shadow copy of the grid predicts each
// result beat, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_influence_grid_disc_stamp_and_query_core;

    localparam logic [1:0] OP_UNUSED = 2'd3;   // no defined op, result is zero
    localparam int         CELL_TOP  = 24'hFF_FFFF;

    // ------------------------------------------------------------------------
    // Shadow grid: mirrors cell contents and size registers, holds the
    // result beats still owed by the block.
    // ------------------------------------------------------------------------
    class influence_shadow;
        logic [idsq_pkg::CELL_W-1:0] cells [0:idsq_pkg::DEF_MAX_WIDTH*idsq_pkg::DEF_MAX_HEIGHT-1];
        logic [idsq_pkg::SIZE_W-1:0] width_reg;
        logic [idsq_pkg::SIZE_W-1:0] height_reg;
        idsq_pkg::rsp_item_t         pending_sums[$];
        int                          errors;
        int                          n_add;
        int                          n_query;
        int                          n_nonzero;
        int                          n_clear;
        int                          n_unused;

        function new();
            foreach (cells[k]) cells[k] = '0;
            width_reg  = idsq_pkg::SIZE_RESET;
            height_reg = idsq_pkg::SIZE_RESET;
            errors     = 0;
            n_add      = 0;
            n_query    = 0;
            n_nonzero  = 0;
            n_clear    = 0;
            n_unused   = 0;
        endfunction

        // sizes above the build maximum clip to it
        function int cols_in_use();
            return (int'(width_reg) > idsq_pkg::DEF_MAX_WIDTH) ?
                   idsq_pkg::DEF_MAX_WIDTH : int'(width_reg);
        endfunction

        function int rows_in_use();
            return (int'(height_reg) > idsq_pkg::DEF_MAX_HEIGHT) ?
                   idsq_pkg::DEF_MAX_HEIGHT : int'(height_reg);
        endfunction

        function void stamp_disc(int cx, int cy, int r, int amt);
            int w;
            int h;
            int x;
            int y;
            int d;
            w = cols_in_use();
            h = rows_in_use();
            for (int i = -r; i <= r; i++)
            begin
                for (int j = -r; j <= r; j++)
                begin
                    x = cx + i;
                    y = cy + j;
                    if (x < 0 || x >= w || y < 0 || y >= h) continue;
                    if (i * i + j * j > r * r) continue;
                    d = int'(cells[y * idsq_pkg::DEF_MAX_WIDTH + x]) + amt;
                    if (d < 0) d = 0;
                    if (d > CELL_TOP) d = CELL_TOP;
                    cells[y * idsq_pkg::DEF_MAX_WIDTH + x] = d[idsq_pkg::CELL_W-1:0];
                end
            end
        endfunction

        // 1-2-1 / 2-5-2 / 1-2-1 kernel, off-map neighbors skipped
        function logic [idsq_pkg::SUM_W-1:0] weighted_query(int cx, int cy);
            int          w;
            int          h;
            int          x;
            int          y;
            int          wt;
            logic [31:0] sum;
            w   = cols_in_use();
            h   = rows_in_use();
            sum = '0;
            if (cx < 0 || cx >= w || cy < 0 || cy >= h) return '0;
            for (int i = -1; i <= 1; i++)
            begin
                for (int j = -1; j <= 1; j++)
                begin
                    x = cx + i;
                    y = cy + j;
                    if (x < 0 || x >= w || y < 0 || y >= h) continue;
                    wt  = (i == 0 && j == 0) ? 5 : ((i == 0 || j == 0) ? 2 : 1);
                    sum = sum + cells[y * idsq_pkg::DEF_MAX_WIDTH + x] * wt;
                end
            end
            return sum[idsq_pkg::SUM_W-1:0];
        endfunction

        function void apply_request(idsq_pkg::req_item_t item);
            idsq_pkg::rsp_item_t want;
            int                  r;
            want          = '0;
            want.done_res = 1'b1;
            r = int'(item.radius);
            if (r > idsq_pkg::DEF_MAX_RADIUS) r = idsq_pkg::DEF_MAX_RADIUS;
            case (item.op)
                idsq_pkg::OP_ADD:
                begin
                    stamp_disc(int'(item.col), int'(item.row), r, int'(item.amount));
                    n_add++;
                end
                idsq_pkg::OP_QUERY:
                begin
                    want.weighted_sum = weighted_query(int'(item.col), int'(item.row));
                    n_query++;
                    if (want.weighted_sum != '0) n_nonzero++;
                end
                idsq_pkg::OP_CLEAR:
                begin
                    foreach (cells[k]) cells[k] = '0;
                    n_clear++;
                end
                default: n_unused++;
            endcase
            pending_sums.insert(pending_sums.size(), want);
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_response(idsq_pkg::rsp_item_t got);
            idsq_pkg::rsp_item_t want;
            if (pending_sums.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing outstanding (sum %0h)",
                                          got.weighted_sum));
                return;
            end
            want = pending_sums.pop_front();
            if (got.weighted_sum !== want.weighted_sum)
                report_mismatch($sformatf("weighted_sum %0h, predicted %0h",
                                          got.weighted_sum, want.weighted_sum));
            if (got.done_res !== want.done_res)
                report_mismatch($sformatf("done_res %b, predicted %b",
                                          got.done_res, want.done_res));
        endtask

        task check_leftovers();
            if (pending_sums.size() != 0)
                report_mismatch($sformatf("%0d result beats never arrived",
                                          pending_sums.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    idsq_pkg::req_item_t req       = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    idsq_pkg::rsp_item_t rsp;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [2:0]          paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    influence_shadow shadow = new();

    // handshake knobs shared between the sender and the receiver
    bit idling_on     = 1'b1;
    int rsp_long_hold = 0;      // cycles of forced result stall, picked up by receiver
    int n_long_holds  = 0;
    int n_sizes       = 1;

    influence_grid_disc_stamp_and_query_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hang guard: far beyond a run where every beat is a full clear and
    // every result sits out the longest stall.
    initial
    begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: checks each accepted result beat, then picks the stall for
    // the next edge. Random bursts run only while idling is on; a long hold comes from main.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            // values seen here are the ones the edge used
            if (rst_n && rsp_valid && !rsp_stall)
                shadow.check_response(rsp);
            if (rsp_long_hold > 0)
            begin
                stall_left    = rsp_long_hold;
                rsp_long_hold = 0;
                n_long_holds++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. Every task is entered right after a rising edge.
    // ------------------------------------------------------------------------
    // Offer one beat and hold it until the block takes it. Valid stays high
    // on return so a back-to-back beat needs no re-raise.
    task automatic send_beat(input idsq_pkg::req_item_t item);
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        shadow.apply_request(item);
    endtask

    task automatic send_fields(input logic [1:0] op, input int col, input int row,
                               input int radius,
                               input logic [idsq_pkg::CELL_W-1:0] amount);
        idsq_pkg::req_item_t item;
        item.op     = op;
        item.col    = col[7:0];
        item.row    = row[7:0];
        item.radius = radius[3:0];
        item.amount = amount;
        send_beat(item);
    endtask

    // Random gap on the request side.
    task automatic maybe_gap();
        if (idling_on && $urandom_range(0, 9) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Sender goes quiet until every owed result has been taken.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending_sums.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // APB write then read-back of one size register; block is idle here.
    task automatic write_size(input logic reg_idx,
                              input logic [idsq_pkg::SIZE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {25'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        // read phase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[idsq_pkg::SIZE_W-1:0] !== value)
            shadow.report_mismatch($sformatf("size register %0d reads %0h, written %0h",
                                             reg_idx, prdata[idsq_pkg::SIZE_W-1:0],
                                             value));
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == idsq_pkg::REG_GRID_WIDTH)
            shadow.width_reg = value;
        else
            shadow.height_reg = value;
    endtask

    // Coordinates mostly hug the map so adds and queries overlap; a share
    // spans the whole signed range.
    function automatic logic [7:0] pick_coord(int span);
        int v;
        if ($urandom_range(0, 7) == 0)
            v = $urandom_range(0, 255);
        else
            v = $urandom_range(0, span + 5) - 3;
        return v[7:0];
    endfunction

    function automatic idsq_pkg::req_item_t make_item();
        idsq_pkg::req_item_t item;
        int                  p;
        p = $urandom_range(0, 99);
        if (p < 47)
            item.op = idsq_pkg::OP_ADD;
        else if (p < 94)
            item.op = idsq_pkg::OP_QUERY;
        else if (p < 97)
            item.op = OP_UNUSED;
        else
            item.op = idsq_pkg::OP_CLEAR;
        item.col = pick_coord(shadow.cols_in_use());
        item.row = pick_coord(shadow.rows_in_use());
        // small discs keep the scan short; a few reach the full radius field
        if ($urandom_range(0, 9) == 0)
            item.radius = 4'($urandom_range(0, 15));
        else
            item.radius = 4'($urandom_range(0, 4));
        case ($urandom_range(0, 5))
            0:       item.amount = 24'($urandom());
            1:       item.amount = 24'($urandom_range(1, 4096));
            2:       item.amount = -24'($urandom_range(1, 4096));
            3:       item.amount = 24'h7F_FFFF;
            4:       item.amount = 24'h80_0000;
            default: item.amount = 24'($urandom_range(24'h10_0000, 24'h7F_FFFF));
        endcase
        return item;
    endfunction

    task automatic random_phase(input int count, input bit long_hold);
        for (int k = 0; k < count; k++)
        begin
            // stall the result side for a long stretch while beats keep coming
            if (long_hold && k == 5)
                rsp_long_hold = 3000;
            maybe_gap();
            send_beat(make_item());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [idsq_pkg::SIZE_W-1:0] phase_w [0:8];
        logic [idsq_pkg::SIZE_W-1:0] phase_h [0:8];

        // default size first, then one extreme each: 1x1, zero width,
        // oversized both, narrow, zero height, random, odd, wide but tall
        phase_w = '{7'd64, 7'd1, 7'd0,  7'd127, 7'd5, 7'd64, 7'd0, 7'd33, 7'd64};
        phase_h = '{7'd64, 7'd1, 7'd64, 7'd127, 7'd3, 7'd0,  7'd0, 7'd17, 7'd127};
        phase_w[6] = 7'($urandom_range(1, 64));
        phase_h[6] = 7'($urandom_range(1, 64));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats; the first one also waits out the clearing pass.
        send_fields(idsq_pkg::OP_QUERY, 0, 0, 0, 24'h0);            // empty grid
        send_fields(idsq_pkg::OP_ADD, 10, 10, 0, 24'h7F_FFFF);      // largest positive
        send_fields(idsq_pkg::OP_ADD, 10, 10, 0, 24'h7F_FFFF);      // brings the cell to FF_FFFE
        send_fields(idsq_pkg::OP_QUERY, 10, 10, 0, 24'h0);          // 5 x center cell
        send_fields(idsq_pkg::OP_ADD, 9, 11, 2, 24'h80_0000);       // clamps empty cells to zero
        send_fields(idsq_pkg::OP_QUERY, 10, 11, 0, 24'h0);
        send_fields(idsq_pkg::OP_ADD, -5, -3, 15, 24'h00_1000);     // off-map center
        send_fields(idsq_pkg::OP_ADD, 127, -128, 15, 24'h12_3456);  // touches nothing
        send_fields(idsq_pkg::OP_ADD, -128, 70, 15, 24'h00_0100);
        send_fields(idsq_pkg::OP_QUERY, 0, 0, 0, 24'h0);            // corner
        send_fields(idsq_pkg::OP_QUERY, 63, 63, 0, 24'h0);
        send_fields(idsq_pkg::OP_QUERY, 64, 0, 0, 24'h0);           // just off the map
        send_fields(idsq_pkg::OP_QUERY, -1, 5, 0, 24'h0);
        send_fields(idsq_pkg::OP_QUERY, -128, 127, 15, 24'hFF_FFFF);
        send_fields(OP_UNUSED, 33, -77, 9, 24'hA5_5A5A);            // nothing happens
        send_fields(idsq_pkg::OP_ADD, 63, 63, 15, 24'h12_3456);
        send_fields(idsq_pkg::OP_QUERY, 62, 62, 0, 24'h0);
        send_fields(idsq_pkg::OP_CLEAR, 0, 0, 0, 24'h0);
        send_fields(idsq_pkg::OP_QUERY, 62, 62, 0, 24'h0);          // clear took effect

        // Random phases; sizes only change once the block has drained.
        for (int ph = 0; ph < 9; ph++)
        begin
            drain();
            if (ph != 0)
            begin
                write_size(idsq_pkg::REG_GRID_WIDTH, phase_w[ph]);
                write_size(idsq_pkg::REG_GRID_HEIGHT, phase_h[ph]);
                n_sizes++;
            end
            // last phase runs flat out; others mostly with idling
            if (ph == 8)
                idling_on = 1'b0;
            else
                idling_on = (ph == 0) || ($urandom_range(0, 3) != 0);
            random_phase(67, ph == 0);
        end

        // end of stimulus: wait for the last results, then watch for strays
        drain();
        repeat (200) @(posedge clk);
        shadow.check_leftovers();

        $display("Run covered %0d disc adds, %0d queries (%0d nonzero), %0d clears, %0d unused ops",
                 shadow.n_add, shadow.n_query, shadow.n_nonzero, shadow.n_clear,
                 shadow.n_unused);
        $display("across %0d grid size settings with %0d long result holds",
                 n_sizes, n_long_holds);
        if (shadow.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
